// ===== hdl/hsl_to_rgb_converter_core_defines.svh =====
// Assertion macros shared by the HSL to RGB converter RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HRC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hslrgb_pkg.sv =====
// Types and constants for the HSL to RGB converter.
// Depends on nothing; used by the converter core and its checks.
package hslrgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int IN_W      = FRAC_BITS + 1;
  localparam int CH_W      = 8;
  localparam int NUM_CHAN  = 3;

  localparam logic [IN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam int CHAN_RED   = 0;
  localparam int CHAN_GREEN = 1;
  localparam int CHAN_BLUE  = 2;

  localparam int unsigned CHAN_OFFSET [NUM_CHAN] = '{0, 8, 4};

  typedef struct packed {
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] saturation;
    logic [IN_W-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

// ===== hdl/hsl_to_rgb_converter_core.sv =====
// A request taken with start moves through the s1, s2, s3 and s4 registers into rgb, where it shows with done.
// Throughput: one request per clock; busy is always low and the pipeline never stalls.
// The multipliers are S*min(L,1-L), then a*|t| for each channel, then the scale by 255 for each channel.
// Reset (rst, synchronous, active high) clears the stage valid bits and done only.
// Depends on hslrgb_pkg and hsl_to_rgb_converter_core_defines.svh.
`include "hsl_to_rgb_converter_core_defines.svh"

module hsl_to_rgb_converter_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hslrgb_pkg::hsl_t  hsl,
  output logic              done,
  output hslrgb_pkg::rgb_t  rgb
);

  localparam int FB    = hslrgb_pkg::FRAC_BITS;
  localparam int IW    = hslrgb_pkg::IN_W;
  localparam int NC    = hslrgb_pkg::NUM_CHAN;
  localparam int KW    = FB + 5;
  localparam int TW    = KW + 1;
  localparam int PW    = 2 * IW;
  localparam int VW    = IW + 1;
  localparam int SW    = VW + 8;
  localparam int CW    = SW - FB;

  localparam logic [IW-1:0]        ONE       = hslrgb_pkg::ONE;
  localparam logic [KW-1:0]        K_MOD     = KW'(12) << FB;
  localparam logic signed [TW-1:0] THREE_ONE = TW'(3) << FB;
  localparam logic signed [TW-1:0] NINE_ONE  = TW'(9) << FB;
  localparam logic signed [TW-1:0] ONE_S     = TW'(1) << FB;
  localparam logic signed [TW-1:0] NEG_ONE_S = -ONE_S;
  localparam logic [SW-1:0]        SCALE     = SW'(255);
  localparam logic [CW-1:0]        CH_MAX    = CW'(255);

  logic [3:0] stage_valid;

  // Stage 1: clamp inputs, half-chroma factor, hue position per channel.
  logic [FB-1:0]  hue_frac;
  logic [IW-1:0]  sat_next;
  logic [IW-1:0]  light_next;
  logic [IW-1:0]  light_inv;
  logic [IW-1:0]  lo_next;
  logic [KW-1:0]  k_sum  [NC];
  logic [KW-1:0]  k_next [NC];
  logic [IW-1:0]  s1_sat;
  logic [IW-1:0]  s1_light;
  logic [IW-1:0]  s1_lo;
  logic [KW-1:0]  s1_k [NC];

  // Stage 2: a = S*min(L,1-L) and the clamped triangle term.
  logic [PW-1:0]        sl_prod;
  logic [IW-1:0]        a_next;
  logic signed [TW-1:0] t1 [NC];
  logic signed [TW-1:0] t2 [NC];
  logic signed [TW-1:0] tm [NC];
  logic signed [TW-1:0] tneg [NC];
  logic [IW-1:0]        mag_next [NC];
  logic                 neg_next [NC];
  logic [IW-1:0]        s2_a;
  logic [IW-1:0]        s2_light;
  logic [IW-1:0]        s2_mag [NC];
  logic                 s2_neg [NC];

  // Stage 3: magnitude of a*t.
  logic [PW-1:0] at_prod [NC];
  logic [IW-1:0] s3_light;
  logic [IW-1:0] s3_q [NC];
  logic          s3_neg [NC];

  // Stage 4: channel value, never below zero.
  logic [VW-1:0] v_next [NC];
  logic [VW-1:0] s4_v [NC];

  // Stage 5: scale by 255 and saturate.
  logic [SW-1:0] scaled [NC];
  logic [CW-1:0] c_full [NC];
  logic [7:0]    ch_next [NC];
  hslrgb_pkg::rgb_t rgb_next;

  assign busy = 1'b0;

  always_comb begin
    hue_frac   = hsl.hue[FB-1:0];
    sat_next   = (hsl.saturation > ONE) ? ONE : hsl.saturation;
    light_next = (hsl.lightness > ONE) ? ONE : hsl.lightness;
    light_inv  = ONE - light_next;
    lo_next    = (light_next < light_inv) ? light_next : light_inv;
    for (int i = 0; i < NC; i++) begin
      k_sum[i] = (KW'(hue_frac) << 3) + (KW'(hue_frac) << 2)
               + (KW'(hslrgb_pkg::CHAN_OFFSET[i]) << FB);
      k_next[i] = (k_sum[i] >= K_MOD) ? (k_sum[i] - K_MOD) : k_sum[i];
    end
  end

  always_comb begin
    sl_prod = PW'(s1_sat) * PW'(s1_lo);
    a_next  = sl_prod[FB +: IW];
    for (int i = 0; i < NC; i++) begin
      t1[i]   = $signed({1'b0, s1_k[i]}) - THREE_ONE;
      t2[i]   = NINE_ONE - $signed({1'b0, s1_k[i]});
      tm[i]   = (t1[i] < t2[i]) ? t1[i] : t2[i];
      tneg[i] = -tm[i];
      if (tm[i] > ONE_S) begin
        mag_next[i] = ONE;
        neg_next[i] = 1'b0;
      end else if (tm[i] < NEG_ONE_S) begin
        mag_next[i] = ONE;
        neg_next[i] = 1'b1;
      end else if (tm[i] < 0) begin
        mag_next[i] = tneg[i][IW-1:0];
        neg_next[i] = 1'b1;
      end else begin
        mag_next[i] = tm[i][IW-1:0];
        neg_next[i] = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      at_prod[i] = PW'(s2_a) * PW'(s2_mag[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      if (s3_neg[i]) begin
        v_next[i] = VW'(s3_light) + VW'(s3_q[i]);
      end else if (s3_light >= s3_q[i]) begin
        v_next[i] = VW'(s3_light - s3_q[i]);
      end else begin
        v_next[i] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      scaled[i]  = SW'(s4_v[i]) * SCALE;
      c_full[i]  = scaled[i][FB +: CW];
      ch_next[i] = (c_full[i] > CH_MAX) ? 8'hFF : c_full[i][7:0];
    end
    rgb_next.red   = ch_next[hslrgb_pkg::CHAN_RED];
    rgb_next.green = ch_next[hslrgb_pkg::CHAN_GREEN];
    rgb_next.blue  = ch_next[hslrgb_pkg::CHAN_BLUE];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      done        <= 1'b0;
    end else begin
      stage_valid <= {stage_valid[2:0], start & ~busy};
      done        <= stage_valid[3];
    end
  end

  always_ff @(posedge clk) begin
    s1_sat   <= sat_next;
    s1_light <= light_next;
    s1_lo    <= lo_next;
    s2_a     <= a_next;
    s2_light <= s1_light;
    s3_light <= s2_light;
    for (int i = 0; i < NC; i++) begin
      s1_k[i]   <= k_next[i];
      s2_mag[i] <= mag_next[i];
      s2_neg[i] <= neg_next[i];
      s3_q[i]   <= at_prod[i][FB +: IW];
      s3_neg[i] <= s2_neg[i];
      s4_v[i]   <= v_next[i];
    end
    rgb <= rgb_next;
  end

  `HRC_ASSERT_IMPL(a_done_latency, clk, rst, done, $past(start, 5), "done without a request five cycles earlier")
  `HRC_ASSERT_NEXT(a_empty_quiet, clk, rst, (!start && stage_valid == '0), !done, "done from an empty pipeline")
  `HRC_ASSERT_IMPL(a_full_light, clk, rst, (done && $past(hsl.lightness, 5) >= ONE), (rgb.red == 8'hFF && rgb.green == 8'hFF && rgb.blue == 8'hFF), "full lightness is not white")
  `HRC_ASSERT_IMPL(a_zero_light, clk, rst, (done && $past(hsl.lightness, 5) == '0), (rgb.red == 8'h00 && rgb.green == 8'h00 && rgb.blue == 8'h00), "zero lightness is not black")
  `HRC_ASSERT_IMPL(a_gray, clk, rst, (done && $past(hsl.saturation, 5) == '0), (rgb.red == rgb.green && rgb.green == rgb.blue), "zero saturation is not gray")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for hsl_to_rgb_converter_core: directed and random HSL pixels,
// with each RGB result checked against a fixed-point model of the conversion.
// Depends on hslrgb_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb;
  import hslrgb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 1500;
  localparam int QUIET_TAIL     = 200;
  localparam int ONE_I          = int'(ONE);
  localparam int IN_MAX         = (1 << IN_W) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  hsl_t hsl = '0;
  logic done;
  rgb_t rgb;

  hsl_t pixels_to_send[$];
  rgb_t rgb_due[$];
  int   mismatch_count = 0;
  int   gap_left = 0;
  int   sent_count = 0;
  int   stall_cycles = 0;

  hsl_to_rgb_converter_core uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .hsl   (hsl),
    .done  (done),
    .rgb   (rgb)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [CH_W-1:0] channel_level(longint h, longint s, longint l,
                                                     longint offset);
    longint unit_val, k, lo, a, t, p, v, c;
    unit_val = longint'(1) << FRAC_BITS;
    k = (12 * h + offset * unit_val) % (12 * unit_val);
    lo = (l < unit_val - l) ? l : unit_val - l;
    a = (s * lo) >> FRAC_BITS;
    t = (k - 3 * unit_val < 9 * unit_val - k) ? k - 3 * unit_val : 9 * unit_val - k;
    if (t > unit_val) t = unit_val;
    if (t < -unit_val) t = -unit_val;
    if (t >= 0) p = (a * t) >> FRAC_BITS;
    else p = -((a * -t) >> FRAC_BITS);
    v = l - p;
    if (v < 0) v = 0;
    c = (v * 255) >> FRAC_BITS;
    if (c > 255) c = 255;
    return c[CH_W-1:0];
  endfunction

  function automatic rgb_t convert_pixel(hsl_t px);
    longint h, s, l;
    rgb_t   res;
    h = longint'(px.hue[FRAC_BITS-1:0]);
    s = longint'((px.saturation > ONE) ? ONE : px.saturation);
    l = longint'((px.lightness > ONE) ? ONE : px.lightness);
    res.red   = channel_level(h, s, l, CHAN_OFFSET[CHAN_RED]);
    res.green = channel_level(h, s, l, CHAN_OFFSET[CHAN_GREEN]);
    res.blue  = channel_level(h, s, l, CHAN_OFFSET[CHAN_BLUE]);
    return res;
  endfunction

  function automatic logic [IN_W-1:0] random_fraction();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return ONE;
      2, 3: return IN_W'($urandom_range(ONE_I + 1, IN_MAX));
      default: return IN_W'($urandom_range(0, ONE_I));
    endcase
  endfunction

  task automatic queue_pixel(int h, int s, int l);
    hsl_t px;
    px.hue        = IN_W'(h);
    px.saturation = IN_W'(s);
    px.lightness  = IN_W'(l);
    pixels_to_send.push_back(px);
  endtask

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        rgb_due.push_back(convert_pixel(hsl));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixels_to_send.size() > 0) begin
        hsl <= pixels_to_send.pop_front();
        start <= 1'b1;
        sent_count <= sent_count + 1;
        if (pixels_to_send.size() > QUIET_TAIL && (sent_count / 128) % 3 != 2 &&
            $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(1, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (rgb_due.size() == 0) begin
        flag_mismatch("result with no request pending, rgb", int'(rgb), 0);
      end else begin
        rgb_t want;
        want = rgb_due.pop_front();
        if (rgb.red !== want.red) flag_mismatch("red", int'(rgb.red), int'(want.red));
        if (rgb.green !== want.green) begin
          flag_mismatch("green", int'(rgb.green), int'(want.green));
        end
        if (rgb.blue !== want.blue) flag_mismatch("blue", int'(rgb.blue), int'(want.blue));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    queue_pixel(0, 0, 0);
    queue_pixel(0, 0, ONE_I);
    queue_pixel(0, ONE_I, ONE_I / 2);
    queue_pixel(683, ONE_I, ONE_I / 2);
    queue_pixel(1365, ONE_I, ONE_I / 2);
    queue_pixel(2048, ONE_I, ONE_I / 2);
    queue_pixel(2731, ONE_I, ONE_I / 2);
    queue_pixel(3413, ONE_I, ONE_I / 2);
    queue_pixel(ONE_I - 1, ONE_I, ONE_I / 2);
    queue_pixel(ONE_I, ONE_I, ONE_I / 2);
    queue_pixel(5461, ONE_I, ONE_I / 2);
    queue_pixel(IN_MAX, IN_MAX, IN_MAX);
    queue_pixel(0, IN_MAX, ONE_I / 2);
    queue_pixel(0, ONE_I, IN_MAX);
    queue_pixel(1000, 2000, ONE_I + 1);
    queue_pixel(0, ONE_I, 1);
    queue_pixel(0, ONE_I, ONE_I - 1);
    queue_pixel(2048, 1, 1024);
    queue_pixel(ONE_I, 0, ONE_I / 2);
    queue_pixel(7000, 3000, 3000);
    queue_pixel(ONE_I / 4, ONE_I / 2, ONE_I / 4);
    queue_pixel(3 * ONE_I / 4, ONE_I - 1, 3 * ONE_I / 4);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      queue_pixel($urandom_range(0, IN_MAX), int'(random_fraction()),
                  int'(random_fraction()));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pixels_to_send.size() > 0 || start) @(posedge clk);
    while (rgb_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hslrgb_pkg.sv
hdl/hsl_to_rgb_converter_core.sv
verif/tb.sv
